// ===== rtl/ita_pkg.sv =====
package ita_pkg;

    // value width and digit storage
    localparam int VALUE_BITS = 64;
    localparam int NUM_DIGITS = 22;
    localparam int IDX_W      = $clog2(NUM_DIGITS);
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int USER_W     = 9;
    localparam int DATA_W     = 64;
    localparam int CHAR_W     = 8;

    // radix codes (anything else is hex)
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;

    // operand size codes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // ascii codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;

    // control from the sequencer to the digit unit
    typedef struct packed {
        logic       load;
        logic       shift;
        logic [1:0] radix;
    } t_dig_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_PFX0,
        ST_PFX1,
        ST_DIGITS
    } t_state;

    // one digit to its ascii character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UC_A : CH_LC_A;
        if (d < 4'd10) begin
            digit_char = CH_ZERO + {4'd0, d};
        end else begin
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== rtl/ita_digits.sv =====
module ita_digits (
    input  logic                            i_clk,
    input  ita_pkg::t_dig_ctrl              i_ctrl,
    input  logic [ita_pkg::VALUE_BITS-1:0]  i_value,
    input  logic [ita_pkg::IDX_W-1:0]       i_rd_idx,
    output logic [3:0]                      o_rd_digit
);

    logic [3:0]                     r_dig [ita_pkg::NUM_DIGITS];
    logic [ita_pkg::VALUE_BITS-1:0] r_val;
    logic [3:0]                     adj   [ita_pkg::NUM_DIGITS];
    logic [3*ita_pkg::NUM_DIGITS-1:0] oct_bits;
    logic [4*ita_pkg::NUM_DIGITS-1:0] hex_bits;

    // add-three correction of every bcd digit before the shift
    always_comb begin
        for (int i = 0; i < ita_pkg::NUM_DIGITS; i++) begin
            adj[i] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
    end

    assign oct_bits = {{(3*ita_pkg::NUM_DIGITS-ita_pkg::VALUE_BITS){1'b0}}, i_value};
    assign hex_bits = {{(4*ita_pkg::NUM_DIGITS-ita_pkg::VALUE_BITS){1'b0}}, i_value};

    // digit store: direct split for octal and hex, shift-add-three for decimal
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_val <= i_value;
            for (int i = 0; i < ita_pkg::NUM_DIGITS; i++) begin
                case (i_ctrl.radix)
                    ita_pkg::RADIX_DEC: r_dig[i] <= 4'd0;
                    ita_pkg::RADIX_OCT: r_dig[i] <= {1'b0, oct_bits[3*i +: 3]};
                    default:            r_dig[i] <= hex_bits[4*i +: 4];
                endcase
            end
        end else if (i_ctrl.shift) begin
            r_val    <= {r_val[ita_pkg::VALUE_BITS-2:0], 1'b0};
            r_dig[0] <= {adj[0][2:0], r_val[ita_pkg::VALUE_BITS-1]};
            for (int i = 1; i < ita_pkg::NUM_DIGITS; i++) begin
                r_dig[i] <= {adj[i][2:0], adj[i-1][3]};
            end
        end
    end

    assign o_rd_digit = r_dig[i_rd_idx];

endmodule

// ===== rtl/integer_to_ascii_formatter.sv =====
// channel  | dir | tvalid/tready           | payload
// ---------+-----+-------------------------+--------------------------------------------
// input    | in  | i_s_tvalid / o_s_tready | i_s_tdata value, i_s_tuser conversion flags
// output   | out | o_m_tvalid / i_m_tready | o_m_tdata ascii char, o_m_tlast final char
//
// one number at a time; decimal runs the value through the shift-add-three loop,
// octal and hex load their digits in the accept cycle.
// the digit scan then drops leading zeros down to the first nonzero or last digit, and
// the sign, the prefix and the digits go out in that order, the last digit with tlast.
// i_rst_n is synchronous, active low, and clears the sequencer and output valid.
// a stalled output holds its character; the sequencer waits on it.
module integer_to_ascii_formatter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ita_pkg::DATA_W-1:0]      i_s_tdata,  // [63:0] value
    // [1:0] radix, [2] upper_case, [3] is_signed, [4] alt_form,
    // [5] force_plus, [6] blank_sign, [8:7] operand_size
    input  logic [ita_pkg::USER_W-1:0]      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ita_pkg::CHAR_W-1:0]      o_m_tdata,  // [7:0] out_char
    output logic                            o_m_tlast   // last_char
);

    ita_pkg::t_state               r_state, n_state;
    logic [ita_pkg::CNT_W-1:0]     r_cnt;
    logic [ita_pkg::IDX_W-1:0]     r_idx;
    logic [ita_pkg::CHAR_W-1:0]    r_sign_char;
    logic                          r_has_sign;
    logic                          r_pfx0;
    logic                          r_hex;
    logic                          r_upper;
    logic                          r_out_valid;
    logic [ita_pkg::CHAR_W-1:0]    r_out_char;
    logic                          r_out_last;

    logic                          s_fire;
    logic                          out_free;
    logic                          emit;
    logic                          emit_last;
    logic [ita_pkg::CHAR_W-1:0]    emit_char;
    logic                          idx_dec;
    logic                          cnt_inc;
    ita_pkg::t_dig_ctrl            dig_ctrl;
    logic [3:0]                    rd_digit;

    // input field unpacking
    logic [1:0]                    in_radix;
    logic                          in_upper, in_sgn, in_alt, in_plus, in_blank;
    logic [1:0]                    in_size;
    logic [ita_pkg::VALUE_BITS-1:0] mask, v, mag;
    logic                          msb, signed_conv, neg, is_hex;

    assign in_radix = i_s_tuser[1:0];
    assign in_upper = i_s_tuser[2];
    assign in_sgn   = i_s_tuser[3];
    assign in_alt   = i_s_tuser[4];
    assign in_plus  = i_s_tuser[5];
    assign in_blank = i_s_tuser[6];
    assign in_size  = i_s_tuser[8:7];

    // truncate to operand size, take the magnitude of negative signed decimals
    always_comb begin
        case (in_size)
            ita_pkg::SIZE_8:  mask = {{(ita_pkg::VALUE_BITS-8){1'b0}}, {8{1'b1}}};
            ita_pkg::SIZE_16: mask = {{(ita_pkg::VALUE_BITS-16){1'b0}}, {16{1'b1}}};
            ita_pkg::SIZE_32: mask = {{(ita_pkg::VALUE_BITS-32){1'b0}}, {32{1'b1}}};
            default:          mask = {ita_pkg::VALUE_BITS{1'b1}};
        endcase
        v = i_s_tdata & mask;
        case (in_size)
            ita_pkg::SIZE_8:  msb = v[7];
            ita_pkg::SIZE_16: msb = v[15];
            ita_pkg::SIZE_32: msb = v[31];
            default:          msb = v[ita_pkg::VALUE_BITS-1];
        endcase
        signed_conv = in_sgn && (in_radix == ita_pkg::RADIX_DEC);
        neg         = signed_conv && msb;
        mag         = neg ? ((~v + 1'b1) & mask) : v;
        is_hex      = (in_radix != ita_pkg::RADIX_DEC) && (in_radix != ita_pkg::RADIX_OCT);
    end

    assign o_s_tready = (r_state == ita_pkg::ST_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    // digit store and decimal conversion
    ita_digits u_digits (
        .i_clk      (i_clk),
        .i_ctrl     (dig_ctrl),
        .i_value    (mag),
        .i_rd_idx   (r_idx),
        .o_rd_digit (rd_digit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ita_pkg::ST_IDLE: begin
                if (s_fire) begin
                    n_state = (in_radix == ita_pkg::RADIX_DEC) ? ita_pkg::ST_CONV
                                                               : ita_pkg::ST_SKIP;
                end
            end
            ita_pkg::ST_CONV: begin
                if (r_cnt == {ita_pkg::CNT_W{1'b1}}) n_state = ita_pkg::ST_SKIP;
            end
            ita_pkg::ST_SKIP: begin
                if (r_idx == '0 || rd_digit != 4'd0) n_state = ita_pkg::ST_SIGN;
            end
            ita_pkg::ST_SIGN: begin
                if (!r_has_sign || out_free) n_state = ita_pkg::ST_PFX0;
            end
            ita_pkg::ST_PFX0: begin
                if (!r_pfx0) begin
                    n_state = ita_pkg::ST_DIGITS;
                end else if (out_free) begin
                    n_state = r_hex ? ita_pkg::ST_PFX1 : ita_pkg::ST_DIGITS;
                end
            end
            ita_pkg::ST_PFX1: begin
                if (out_free) n_state = ita_pkg::ST_DIGITS;
            end
            ita_pkg::ST_DIGITS: begin
                if (out_free && r_idx == '0) n_state = ita_pkg::ST_IDLE;
            end
            default: n_state = ita_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        emit           = 1'b0;
        emit_last      = 1'b0;
        emit_char      = ita_pkg::CH_ZERO;
        idx_dec        = 1'b0;
        cnt_inc        = 1'b0;
        dig_ctrl.load  = s_fire;
        dig_ctrl.shift = 1'b0;
        dig_ctrl.radix = in_radix;
        case (r_state)
            ita_pkg::ST_CONV: begin
                dig_ctrl.shift = 1'b1;
                cnt_inc        = 1'b1;
            end
            ita_pkg::ST_SKIP: begin
                idx_dec = (r_idx != '0) && (rd_digit == 4'd0);
            end
            ita_pkg::ST_SIGN: begin
                emit      = r_has_sign && out_free;
                emit_char = r_sign_char;
            end
            ita_pkg::ST_PFX0: begin
                emit      = r_pfx0 && out_free;
                emit_char = ita_pkg::CH_ZERO;
            end
            ita_pkg::ST_PFX1: begin
                emit      = out_free;
                emit_char = ita_pkg::CH_X;
            end
            ita_pkg::ST_DIGITS: begin
                emit      = out_free;
                emit_last = (r_idx == '0);
                emit_char = ita_pkg::digit_char(rd_digit, r_upper);
                idx_dec   = out_free && (r_idx != '0);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ita_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (s_fire) begin
                r_cnt <= '0;
                r_idx <= ita_pkg::IDX_W'(ita_pkg::NUM_DIGITS - 1);
            end else begin
                if (cnt_inc) r_cnt <= r_cnt + 1'b1;
                if (idx_dec) r_idx <= r_idx - 1'b1;
            end
        end
    end

    // per-number text settings
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_sign_char <= neg ? ita_pkg::CH_MINUS
                         : (in_plus ? ita_pkg::CH_PLUS : ita_pkg::CH_SPACE);
            r_has_sign  <= signed_conv && (neg || in_plus || in_blank);
            r_hex       <= is_hex;
            r_upper     <= is_hex && in_upper;
            r_pfx0      <= in_alt && (is_hex ||
                           ((in_radix == ita_pkg::RADIX_OCT) && (mag != '0)));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char <= emit_char;
            r_out_last <= emit_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

    // checks
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == ita_pkg::ST_IDLE))
        else $error("last character did not end the number");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> (r_state == ita_pkg::ST_CONV || r_state == ita_pkg::ST_SKIP))
        else $error("accepted number did not start conversion");

    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ita_pkg::ST_CONV && r_cnt == {ita_pkg::CNT_W{1'b1}})
        |=> (r_state == ita_pkg::ST_SKIP))
        else $error("decimal conversion overran");

    a_no_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_out_valid) |-> i_m_tready)
        else $error("output overwritten while stalled");

endmodule
